>>> hw/rtl/ble_adv_data_filter_parser_defines.svh
// ---------------------------------------------------------------------------
// BLE advertising data parser - assertion macros
// Shared assertion forms; each expects clk and rst_n in the calling scope.
// ---------------------------------------------------------------------------
`ifndef BLE_ADV_DATA_FILTER_PARSER_DEFINES_SVH
`define BLE_ADV_DATA_FILTER_PARSER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define BLEADV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define BLEADV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bleadv_pkg.sv
// ---------------------------------------------------------------------------
// BLE advertising data parser - package
// Types, AD type codes, discovery modes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package bleadv_pkg;

  // Default cap on the report length
  localparam int unsigned MAX_REPORT_BYTES_DEF = 31;

  // Configuration register indexes
  localparam logic CFG_IDX_MODE  = 1'b0;
  localparam logic CFG_IDX_LIMIT = 1'b1;

  // Configuration reset values
  localparam logic [1:0] MODE_RST  = 2'd0;
  localparam logic [4:0] LIMIT_RST = 5'd29;

  // Discovery modes
  localparam logic [1:0] MODE_ALL     = 2'd0;
  localparam logic [1:0] MODE_LIMITED = 2'd1;
  localparam logic [1:0] MODE_GENERAL = 2'd2;

  // AD structure types
  localparam logic [7:0] AD_FLAGS      = 8'h01;
  localparam logic [7:0] AD_NAME_SHORT = 8'h08;
  localparam logic [7:0] AD_NAME_FULL  = 8'h09;

  // Position within one AD structure
  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_VALUE,
    PH_FLAGVAL
  } phase_t;

  // Progress of the local name
  typedef enum logic [1:0] {
    NAME_NONE,
    NAME_PASS,
    NAME_DONE,
    NAME_FAIL
  } name_state_t;

  typedef struct packed {
    logic [1:0] discovery_mode;
    logic [4:0] name_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_byte_valid;
    logic       report_done;
    logic       accept;
    logic       name_ok;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/bleadv_parse.sv
// ---------------------------------------------------------------------------
// BLE advertising data parser - AD structure walker
// Tracks the length/type/value phases of one report and forms the result
// for each accepted byte.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ble_adv_data_filter_parser_defines.svh"

module bleadv_parse #(
  parameter int unsigned MAX_REPORT_BYTES = bleadv_pkg::MAX_REPORT_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [7:0]       data_byte,
  input  wire logic [4:0]       report_length,
  input  wire logic             last,
  input  wire bleadv_pkg::cfg_t cfg,
  output bleadv_pkg::result_t   result
);

  logic [5:0]              offset_r, offset_nxt;
  bleadv_pkg::phase_t      phase_r, phase_nxt;
  logic [7:0]              rem_r, rem_nxt;
  logic                    flags_seen_r, flags_seen_nxt;
  logic [7:0]              flags_value_r, flags_value_nxt;
  bleadv_pkg::name_state_t name_r, name_nxt;
  logic                    ended_r, ended_nxt;

  logic [4:0] eff;
  logic       active;
  logic [8:0] field_end;
  logic [7:0] rem_dec;
  logic       cap;
  logic       verdict;

  // Effective report length
  assign eff    = ({3'b000, report_length} < 8'(MAX_REPORT_BYTES)) ?
                  report_length : 5'(MAX_REPORT_BYTES);
  assign active = !ended_r && (offset_r < {1'b0, eff});
  assign field_end = 9'(offset_r) + 9'd1 + 9'(data_byte);
  assign rem_dec   = rem_r - 8'd1;

  // Walk one byte and form its result
  always_comb begin
    offset_nxt      = offset_r;
    phase_nxt       = phase_r;
    rem_nxt         = rem_r;
    flags_seen_nxt  = flags_seen_r;
    flags_value_nxt = flags_value_r;
    name_nxt        = name_r;
    ended_nxt       = ended_r;
    cap             = 1'b0;
    verdict         = 1'b0;
    result          = '0;

    if (active) begin
      case (phase_r)
        bleadv_pkg::PH_LEN: begin
          if (data_byte == 8'd0) begin
            ended_nxt = 1'b1;
          end else if (field_end > 9'(eff)) begin
            // structure overruns the report
            ended_nxt = 1'b1;
            if (name_r == bleadv_pkg::NAME_NONE) begin
              name_nxt = bleadv_pkg::NAME_FAIL;
            end
          end else begin
            rem_nxt   = data_byte;
            phase_nxt = bleadv_pkg::PH_TYPE;
          end
        end
        bleadv_pkg::PH_TYPE: begin
          rem_nxt = rem_dec;
          if (data_byte == bleadv_pkg::AD_FLAGS && !flags_seen_r) begin
            cap             = 1'b1;
            flags_seen_nxt  = 1'b1;
            flags_value_nxt = 8'd0;
          end
          if ((data_byte == bleadv_pkg::AD_NAME_SHORT ||
               data_byte == bleadv_pkg::AD_NAME_FULL) &&
              name_r == bleadv_pkg::NAME_NONE) begin
            if (rem_dec > 8'(cfg.name_limit)) begin
              name_nxt = bleadv_pkg::NAME_FAIL;
            end else if (rem_dec == 8'd0) begin
              name_nxt = bleadv_pkg::NAME_DONE;
            end else begin
              name_nxt = bleadv_pkg::NAME_PASS;
            end
          end
          if (rem_dec == 8'd0) begin
            phase_nxt = bleadv_pkg::PH_LEN;
          end else begin
            phase_nxt = cap ? bleadv_pkg::PH_FLAGVAL : bleadv_pkg::PH_VALUE;
          end
        end
        default: begin
          if (phase_r == bleadv_pkg::PH_FLAGVAL) begin
            flags_value_nxt = data_byte;
          end
          if (name_r == bleadv_pkg::NAME_PASS) begin
            result.name_byte       = data_byte;
            result.name_byte_valid = 1'b1;
          end
          rem_nxt = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_nxt = bleadv_pkg::PH_LEN;
            if (name_r == bleadv_pkg::NAME_PASS) begin
              name_nxt = bleadv_pkg::NAME_DONE;
            end
          end else begin
            phase_nxt = bleadv_pkg::PH_VALUE;
          end
        end
      endcase
    end

    // Saturate the offset
    if (offset_r != 6'd63) begin
      offset_nxt = offset_r + 6'd1;
    end

    // Discovery verdict on the updated flags
    case (cfg.discovery_mode)
      bleadv_pkg::MODE_ALL:     verdict = 1'b1;
      bleadv_pkg::MODE_LIMITED: verdict = flags_seen_nxt && flags_value_nxt[0];
      bleadv_pkg::MODE_GENERAL: verdict = flags_seen_nxt && (|flags_value_nxt[1:0]);
      default:                  verdict = 1'b0;
    endcase

    // Close the report on its final byte
    if (last) begin
      result.report_done = 1'b1;
      result.accept      = verdict;
      result.name_ok     = (name_nxt == bleadv_pkg::NAME_DONE);
      offset_nxt         = 6'd0;
      phase_nxt          = bleadv_pkg::PH_LEN;
      rem_nxt            = 8'd0;
      flags_seen_nxt     = 1'b0;
      flags_value_nxt    = 8'd0;
      name_nxt           = bleadv_pkg::NAME_NONE;
      ended_nxt          = 1'b0;
    end
  end

  // Hold state between requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r      <= 6'd0;
      phase_r       <= bleadv_pkg::PH_LEN;
      rem_r         <= 8'd0;
      flags_seen_r  <= 1'b0;
      flags_value_r <= 8'd0;
      name_r        <= bleadv_pkg::NAME_NONE;
      ended_r       <= 1'b0;
    end else if (fire) begin
      offset_r      <= offset_nxt;
      phase_r       <= phase_nxt;
      rem_r         <= rem_nxt;
      flags_seen_r  <= flags_seen_nxt;
      flags_value_r <= flags_value_nxt;
      name_r        <= name_nxt;
      ended_r       <= ended_nxt;
    end
  end

  `BLEADV_ASSERT_SAME(a_verdict_only_at_end, fire && !last,
    !result.accept && !result.name_ok, "verdict outside final byte")
  `BLEADV_ASSERT_NEXT(a_clear_after_last, fire && last,
    phase_r == bleadv_pkg::PH_LEN && offset_r == 6'd0 && !ended_r,
    "report state not cleared")
  `BLEADV_ASSERT_SAME(a_name_byte_in_pass, fire && result.name_byte_valid,
    name_r == bleadv_pkg::NAME_PASS, "name byte outside name field")

endmodule

`default_nettype wire

>>> hw/rtl/bleadv_obuf.sv
// ---------------------------------------------------------------------------
// BLE advertising data parser - result queue
// Two-entry result register so a new request is taken while a result waits.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ble_adv_data_filter_parser_defines.svh"

module bleadv_obuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire bleadv_pkg::result_t push_data,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output bleadv_pkg::result_t      pop_data
);

  bleadv_pkg::result_t entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store the incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  `BLEADV_ASSERT_SAME(a_count_range, 1'b1, count_r != 2'd3, "queue count out of range")
  `BLEADV_ASSERT_NEXT(a_pop_drains, pop && !push,
    count_r == $past(count_r) - 2'd1, "pop did not drain an entry")
  `BLEADV_ASSERT_NEXT(a_push_fills, push && !pop,
    count_r == $past(count_r) + 2'd1 && pop_valid, "push did not fill an entry")

endmodule

`default_nettype wire

>>> hw/rtl/ble_adv_data_filter_parser.sv
// ---------------------------------------------------------------------------
// BLE advertising data filter and name parser
// Walks the AD structures of one report, passes the first local name through
// and gives a discovery verdict on the final byte.
// ---------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                       | tuser / tlast
//  in_     | in  | data_byte[7:0], report_length[12:8]      | tlast = last
//  out_    | out | name_byte[7:0], accept[8], name_ok[9]    | tuser = name_byte_valid,
//          |     |                                          | tlast = report_done
//  cfg_    | in  | index 0 discovery_mode, 1 name_limit     | -
//
//  One byte per cycle while in_tready is high; each result is registered in the result queue.
//  The parse state updates in the accepting cycle and a two-entry result
//  queue sets the stall point: in_tready drops only when both entries wait.
//  Reset clears the report state and loads discovery_mode 0, name_limit 29.
//  Configuration writes are always taken.
// ---------------------------------------------------------------------------
`default_nettype none

module ble_adv_data_filter_parser #(
  parameter int unsigned MAX_REPORT_BYTES = bleadv_pkg::MAX_REPORT_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // data_byte[7:0], report_length[12:8], zero pad
  input  wire logic [15:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // name_byte[7:0], accept[8], name_ok[9], zero pad
  output logic [15:0]      out_tdata,
  // name_byte_valid[0]
  output logic             out_tuser,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);

  bleadv_pkg::cfg_t    cfg_r;
  bleadv_pkg::result_t res;
  bleadv_pkg::result_t res_out;
  logic                in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.discovery_mode <= bleadv_pkg::MODE_RST;
      cfg_r.name_limit     <= bleadv_pkg::LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bleadv_pkg::CFG_IDX_MODE:  cfg_r.discovery_mode <= cfg_data[1:0];
        bleadv_pkg::CFG_IDX_LIMIT: cfg_r.name_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // AD structure walker
  bleadv_parse #(
    .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .data_byte    (in_tdata[7:0]),
    .report_length(in_tdata[12:8]),
    .last         (in_tlast),
    .cfg          (cfg_r),
    .result       (res)
  );

  // Result queue
  bleadv_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_tvalid),
    .push_ready(in_tready),
    .push_data (res),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (res_out)
  );

  // Pack the result request
  assign out_tdata = {6'b000000, res_out.name_ok, res_out.accept, res_out.name_byte};
  assign out_tuser = res_out.name_byte_valid;
  assign out_tlast = res_out.report_done;

endmodule

`default_nettype wire

>>> sim/bleadv_report_checker.sv
// ---------------------------------------------------------------------------
// BLE advertising data parser - result checker
// Watches the request, result and register channels of the parser. Keeps its
// own copy of the parse state and the registers, predicts one result for
// every accepted request and compares each accepted result, field by field,
// with the oldest prediction.
// ---------------------------------------------------------------------------
module bleadv_report_checker
  import bleadv_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_REPORT_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       in_tdata,
  input  logic              in_tlast,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       out_tdata,
  input  logic              out_tuser,
  input  logic              out_tlast,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [4:0]        cfg_data,
  output int unsigned       err_count,
  output int unsigned       pending,
  output int unsigned       reports_seen,
  output int unsigned       name_bytes_seen,
  output int unsigned       accepts_seen
);

  // Register copies
  logic [1:0]  disc_mode;
  logic [4:0]  name_limit;

  // Parse state of the current report
  logic [5:0]  offset;
  phase_t      phase;
  logic [7:0]  remaining;
  logic [7:0]  ad_kind;
  logic        flags_found;
  logic [7:0]  flags_byte;
  name_state_t name_st;
  logic        parse_over;

  // Results predicted but not yet seen
  result_t     results_due [$];

  function automatic void clear_report();
    offset      = '0;
    phase       = PH_LEN;
    remaining   = '0;
    ad_kind     = '0;
    flags_found = 1'b0;
    flags_byte  = '0;
    name_st     = NAME_NONE;
    parse_over  = 1'b0;
  endfunction

  // Advance the parse by one report byte and return its result
  function automatic result_t parse_byte(input logic [7:0] b, input logic [4:0] rlen,
                                         input logic is_last);
    result_t     r;
    int unsigned eff;
    logic        grab;
    r    = '0;
    grab = 1'b0;
    eff  = (rlen < MAX_BYTES) ? rlen : MAX_BYTES;
    if (!parse_over && offset < eff) begin
      case (phase)
        PH_LEN: begin
          if (b == 8'h00) begin
            parse_over = 1'b1;
          end else if (int'(offset) + 1 + int'(b) > int'(eff)) begin
            // structure runs past the report: stop, name is unknown
            parse_over = 1'b1;
            if (name_st == NAME_NONE) name_st = NAME_FAIL;
          end else begin
            remaining = b;
            phase     = PH_TYPE;
          end
        end
        PH_TYPE: begin
          ad_kind   = b;
          remaining = remaining - 8'd1;
          if (b == AD_FLAGS && !flags_found) begin
            flags_found = 1'b1;
            flags_byte  = '0;
            grab        = 1'b1;
          end
          if ((b == AD_NAME_SHORT || b == AD_NAME_FULL) && name_st == NAME_NONE) begin
            if (remaining > name_limit) name_st = NAME_FAIL;
            else if (remaining == 8'd0) name_st = NAME_DONE;
            else name_st = NAME_PASS;
          end
          if (remaining == 8'd0) phase = PH_LEN;
          else if (grab) phase = PH_FLAGVAL;
          else phase = PH_VALUE;
        end
        default: begin
          if (phase == PH_FLAGVAL) flags_byte = b;
          if (name_st == NAME_PASS) begin
            r.name_byte       = b;
            r.name_byte_valid = 1'b1;
          end
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) begin
            phase = PH_LEN;
            if (name_st == NAME_PASS) name_st = NAME_DONE;
          end else begin
            phase = PH_VALUE;
          end
        end
      endcase
    end
    if (offset != 6'd63) offset = offset + 6'd1;
    // Verdict on the final byte, then start afresh
    if (is_last) begin
      r.report_done = 1'b1;
      case (disc_mode)
        MODE_ALL:     r.accept = 1'b1;
        MODE_LIMITED: r.accept = flags_found && flags_byte[0];
        MODE_GENERAL: r.accept = flags_found && (flags_byte[1:0] != 2'b00);
        default:      r.accept = 1'b0;
      endcase
      r.name_ok = (name_st == NAME_DONE);
      clear_report();
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
      err_count++;
    end
  endtask

  initial begin
    err_count       = 0;
    pending         = 0;
    reports_seen    = 0;
    name_bytes_seen = 0;
    accepts_seen    = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      disc_mode  = MODE_RST;
      name_limit = LIMIT_RST;
      clear_report();
      results_due.delete();
      pending = 0;
    end else begin
      // Compare the result taken at this edge with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, got tdata %h tuser %b tlast %b",
                   $time, out_tdata, out_tuser, out_tlast);
          err_count++;
        end else begin
          want = results_due.pop_front();
          pending--;
          check_field("name_byte", want.name_byte, out_tdata[7:0]);
          check_field("name_byte_valid", want.name_byte_valid, out_tuser);
          check_field("report_done", want.report_done, out_tlast);
          check_field("accept", want.accept, out_tdata[8]);
          check_field("name_ok", want.name_ok, out_tdata[9]);
        end
        if (out_tlast) reports_seen++;
        if (out_tuser) name_bytes_seen++;
        if (out_tlast && out_tdata[8]) accepts_seen++;
      end
      // Predict the result of a request taken at this edge
      if (in_tvalid && in_tready) begin
        results_due.push_back(parse_byte(in_tdata[7:0], in_tdata[12:8], in_tlast));
        pending++;
      end
      // Follow register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_MODE) disc_mode = cfg_data[1:0];
        else name_limit = cfg_data;
      end
    end
  end

endmodule

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// BLE advertising data parser - testbench top
// Drives report bytes and register writes into the parser with random gaps
// and result back-pressure; the checker beside the block predicts and
// compares every result. A short directed set of reports is followed by
// mostly well-formed random reports under several register settings.
// ---------------------------------------------------------------------------
module tb_top;
  import bleadv_pkg::*;

  localparam logic [1:0]  MODE_RESERVED = 2'd3;
  localparam int unsigned N_SETTINGS    = 6;
  localparam int unsigned PHASE_ITEMS   = 63;
  localparam int unsigned HOLD_CYCLES   = 40;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RUN_LIMIT     = 3000000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = 1'b0;
  logic [4:0]  cfg_data   = '0;

  int unsigned err_count, pending, reports_seen, name_bytes_seen, accepts_seen;

  // Idling bounds, long hold-off handshake and request count
  int unsigned tx_max     = 0;
  int unsigned rx_max     = 0;
  logic        hold_req   = 1'b0;
  logic        hold_done  = 1'b0;
  int unsigned items_sent = 0;

  // Report under construction
  logic [7:0]  ad_bytes [$];

  // Register settings and idling per random phase
  logic [1:0]  set_mode  [N_SETTINGS] = '{MODE_LIMITED, MODE_GENERAL, MODE_RESERVED,
                                          MODE_GENERAL, MODE_LIMITED, MODE_ALL};
  int unsigned set_limit [N_SETTINGS] = '{31, 0, 5, 15, 3, 31};
  int unsigned set_tx    [N_SETTINGS] = '{9, 0, 9, 0, 9, 9};
  int unsigned set_rx    [N_SETTINGS] = '{9, 0, 0, 9, 9, 9};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ble_adv_data_filter_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bleadv_report_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .err_count       (err_count),
    .pending         (pending),
    .reports_seen    (reports_seen),
    .name_bytes_seen (name_bytes_seen),
    .accepts_seen    (accepts_seen)
  );

  // Offer one report byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] data, input logic [4:0] rlen,
                           input logic is_last);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {3'b000, rlen, data};
    in_tlast  <= is_last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    items_sent++;
  endtask

  // Send nsend bytes of the built report; bytes from 64 on repeat the start
  task automatic send_report(input logic [4:0] rlen, input int unsigned nsend,
                             input logic len_noise);
    int unsigned idx;
    logic [7:0]  b;
    for (int unsigned i = 0; i < nsend; i++) begin
      idx = (i >= 64) ? i - 64 : i;
      b = (idx < ad_bytes.size()) ? ad_bytes[idx] : 8'($urandom);
      send_byte(b, len_noise ? 5'($urandom) : rlen, i == nsend - 1);
    end
  endtask

  // Build a chain of AD structures with random content, mostly well-formed
  task automatic make_report(output int unsigned rlen);
    int unsigned room, vlen, pick;
    logic [7:0]  ad;
    ad_bytes.delete();
    rlen = $urandom_range(3, 31);
    while (ad_bytes.size() < rlen) begin
      room = rlen - ad_bytes.size();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        ad_bytes.push_back(8'h00);
        break;
      end
      if (pick < 38) begin
        ad   = AD_FLAGS;
        vlen = $urandom_range(0, 2);
      end else if (pick < 68) begin
        ad   = pick[0] ? AD_NAME_SHORT : AD_NAME_FULL;
        vlen = $urandom_range(0, room);
      end else begin
        ad   = 8'($urandom);
        if (ad == AD_FLAGS || ad == AD_NAME_SHORT || ad == AD_NAME_FULL) ad = 8'hFF;
        vlen = $urandom_range(0, 5);
      end
      // mostly fit the room left, now and then overrun it
      if ($urandom_range(0, 9) != 0 && vlen + 2 > room) vlen = (room >= 2) ? room - 2 : 0;
      ad_bytes.push_back(8'(vlen + 1));
      ad_bytes.push_back(ad);
      repeat (vlen) ad_bytes.push_back(8'($urandom));
    end
  endtask

  // Drop the request line and wait until every result is in
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result sink: random stalls, and one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        stall     = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall = $urandom_range(0, rx_max);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin : stimulus
    int unsigned rlen, nsend, pick, goal;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed reports under reset settings
    tx_max = 3;
    rx_max = 3;
    // flags 0x05 and a one-letter complete name
    ad_bytes = '{8'h02, AD_FLAGS, 8'h05, 8'h02, AD_NAME_FULL, 8'h41};
    send_report(5'd6, 6, 1'b0);
    // flags without a value and an empty short name
    ad_bytes = '{8'h01, AD_FLAGS, 8'h01, AD_NAME_SHORT};
    send_report(5'd4, 4, 1'b0);
    // structure overrunning the report, closed early
    ad_bytes = '{8'hFF, AD_NAME_FULL, 8'h00};
    send_report(5'd31, 3, 1'b0);
    // zero length ends the parse, then a byte beyond the report length
    ad_bytes = '{8'h00, 8'h01, 8'h02};
    send_report(5'd2, 3, 1'b0);
    // empty report length
    ad_bytes = '{8'hFF};
    send_report(5'd0, 1, 1'b0);
    // last arrives in the middle of the name
    ad_bytes = '{8'h05, AD_NAME_FULL, 8'h61, 8'h62};
    send_report(5'd8, 4, 1'b0);

    // Random reports under each setting
    for (int p = 0; p < N_SETTINGS; p++) begin
      wait_idle();
      write_reg(CFG_IDX_MODE, {3'b000, set_mode[p]});
      write_reg(CFG_IDX_LIMIT, 5'(set_limit[p]));
      tx_max = set_tx[p];
      rx_max = set_rx[p];
      if (p == 1) hold_req = 1'b1;
      if (p == 3) begin
        // long report to drive the offset into saturation
        make_report(rlen);
        send_report(5'(rlen), 64 + rlen, 1'b0);
      end
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          make_report(rlen);
          pick = $urandom_range(0, 99);
          if (pick < 70) nsend = rlen;
          else if (pick < 85) nsend = rlen + $urandom_range(1, 4);
          else nsend = $urandom_range(1, rlen);
          send_report(5'(rlen), nsend, 1'b0);
        end else if (pick < 99) begin
          ad_bytes.delete();
          nsend = $urandom_range(1, 8);
          repeat (nsend) ad_bytes.push_back(8'($urandom));
          send_report(5'd0, nsend, 1'b1);
        end else begin
          make_report(rlen);
          send_report(5'(rlen), 64 + $urandom_range(0, 6), 1'b0);
        end
      end
    end

    wait_idle();
    $display("Run covered %0d requests in %0d reports under %0d register settings:",
             items_sent, reports_seen, N_SETTINGS + 1);
    $display("%0d name bytes passed through, %0d reports accepted by the filter.",
             name_bytes_seen, accepts_seen);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : run_limit
    #(RUN_LIMIT);
    $display("Timeout with %0d results outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bleadv_pkg.sv
hw/rtl/bleadv_parse.sv
hw/rtl/bleadv_obuf.sv
hw/rtl/ble_adv_data_filter_parser.sv
sim/bleadv_report_checker.sv
sim/tb_top.sv
